/* design/ecef_pkg.sv */
// ----------------------------------------------------------------------------
// ecef_pkg
// Shared types and constants for the encoder count extender and framer.
// ----------------------------------------------------------------------------
package ecef_pkg;

  localparam int RAW_BITS   = 16;  // width of the raw counter field
  localparam int WRAP_BITS  = 16;  // width of the wrap counter
  localparam int VALUE_BITS = 32;
  localparam int QDEPTH     = 2;   // frame queue depth
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int FRAME_LEN  = 5;
  localparam int BIDX_W     = $clog2(FRAME_LEN);

  // request kinds on the input channel
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_INDEX = 1'b1;

  // status characters
  localparam logic [7:0] CH_HOMED = 8'h73;  // 's'
  localparam logic [7:0] CH_POS   = 8'h70;  // 'p'
  localparam logic [7:0] CH_NEG   = 8'h6E;  // 'n'

  // byte positions within a frame
  localparam logic [BIDX_W-1:0] B_STATUS = BIDX_W'(0);
  localparam logic [BIDX_W-1:0] B_VAL3   = BIDX_W'(1);
  localparam logic [BIDX_W-1:0] B_VAL2   = BIDX_W'(2);
  localparam logic [BIDX_W-1:0] B_VAL1   = BIDX_W'(3);
  localparam logic [BIDX_W-1:0] B_VAL0   = BIDX_W'(4);

  typedef struct packed {
    logic [7:0]            status;
    logic [VALUE_BITS-1:0] value;
  } frame_t;

endpackage

/* design/ecef_front.sv */
// ----------------------------------------------------------------------------
// ecef_front
// Accepts requests, tracks offset and wraps, builds one frame record per tick.
// ----------------------------------------------------------------------------
module ecef_front import ecef_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [RAW_BITS-1:0] in_raw,
  input  logic                in_level,
  input  logic                q_full,
  output logic                push,
  output frame_t              frame
);

  localparam int RAW_W  = (COUNT_BITS < RAW_BITS) ? COUNT_BITS : RAW_BITS;
  localparam int DIFF_W = COUNT_BITS + 2;
  localparam logic signed [DIFF_W-1:0] WRAP_LIM =
    DIFF_W'((64'(1) << (COUNT_BITS - 1)) - 64'(1));

  logic [RAW_W-1:0]      offset_r, offset_nxt;
  logic [RAW_W-1:0]      prev_r, prev_nxt;
  logic [WRAP_BITS-1:0]  wrap_r, wrap_nxt;
  logic                  homed_r, homed_nxt;

  logic                  hs;
  logic [RAW_W-1:0]      raw_m;
  logic [COUNT_BITS-1:0] fine;
  logic signed [DIFF_W-1:0] diff;
  logic [WRAP_BITS-1:0]  wrap_new;
  logic [VALUE_BITS-1:0] wrap_sx;

  assign in_ready = !q_full;
  assign hs       = in_valid && in_ready;
  assign raw_m    = in_raw[RAW_W-1:0];

  assign fine = COUNT_BITS'(raw_m) - COUNT_BITS'(offset_r);
  assign diff = signed'({2'b00, fine}) - signed'(DIFF_W'(prev_r));

  always_comb begin
    wrap_new = wrap_r;
    if (diff > WRAP_LIM) begin
      wrap_new = wrap_r - WRAP_BITS'(1);
    end else if (diff < -WRAP_LIM) begin
      wrap_new = wrap_r + WRAP_BITS'(1);
    end
  end

  // wraps * 2^COUNT_BITS + fine, fine never reaches the wrap bits
  assign wrap_sx      = VALUE_BITS'(signed'(wrap_new));
  assign frame.value  = (wrap_sx << COUNT_BITS) | VALUE_BITS'(fine);
  assign frame.status = homed_r ? CH_HOMED : (in_level ? CH_POS : CH_NEG);
  assign push         = hs && (in_cmd == CMD_TICK);

  always_comb begin
    offset_nxt = offset_r;
    prev_nxt   = prev_r;
    wrap_nxt   = wrap_r;
    homed_nxt  = homed_r;
    if (hs) begin
      if (in_cmd == CMD_INDEX) begin
        if (!homed_r) begin
          offset_nxt = raw_m;
          prev_nxt   = '0;
          wrap_nxt   = '0;
          homed_nxt  = 1'b1;
        end
      end else begin
        prev_nxt = fine[RAW_W-1:0];
        wrap_nxt = wrap_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      prev_r   <= '0;
      wrap_r   <= '0;
      homed_r  <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      prev_r   <= prev_nxt;
      wrap_r   <= wrap_nxt;
      homed_r  <= homed_nxt;
    end
  end

endmodule

/* design/ecef_fifo.sv */
// ----------------------------------------------------------------------------
// ecef_fifo
// Short queue of frame records between front and back.
// ----------------------------------------------------------------------------
module ecef_fifo import ecef_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  frame_t            wr_frame,
  input  logic              pop,
  output frame_t            rd_frame,
  output logic              q_full,
  output logic              q_valid,
  output logic [QCNT_W-1:0] q_count
);

  frame_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_count  = cnt_r;
  assign rd_frame = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* design/ecef_back.sv */
// ----------------------------------------------------------------------------
// ecef_back
// Serialises each frame record into five bytes, one byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ecef_back import ecef_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  frame_t     rd_frame,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic              busy_r, busy_nxt;
  logic [BIDX_W-1:0] idx_r, idx_nxt;
  frame_t            rec_r;
  logic              out_hs;

  assign out_valid = busy_r;
  assign out_last  = (idx_r == B_VAL0);
  assign out_hs    = busy_r && out_ready;
  // next record loads as the last byte leaves, so frames run back to back
  assign pop       = q_valid && (!busy_r || (out_hs && out_last));

  always_comb begin
    case (idx_r)
      B_STATUS: out_byte = rec_r.status;
      B_VAL3:   out_byte = rec_r.value[31:24];
      B_VAL2:   out_byte = rec_r.value[23:16];
      B_VAL1:   out_byte = rec_r.value[15:8];
      B_VAL0:   out_byte = rec_r.value[7:0];
      default:  out_byte = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = B_STATUS;
    end else if (out_hs) begin
      if (out_last) begin
        busy_nxt = 1'b0;
        idx_nxt  = B_STATUS;
      end else begin
        idx_nxt = idx_r + BIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= rd_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= B_STATUS;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

/* design/encoder_count_extend_framer_unit.sv */
// Path: a tick goes into the frame queue, then the serialiser record register.
// Throughput: frames of five bytes leave the byte serialiser one byte per cycle
//   while out_tready is high; ticks and index edges are taken one per cycle while the
//   two-entry frame queue has room, and both wait while it is full.
// Reset: synchronous, active low; clears offset, wraps, homed flag and queue.
// ----------------------------------------------------------------------------
// encoder_count_extend_framer_unit
// Extends a quadrature counter to 32 bits and frames each report as 5 bytes.
// ----------------------------------------------------------------------------
module encoder_count_extend_framer_unit import ecef_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] raw_count, [16] index_level, rest zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast
);

  logic              push, pop, q_full, q_valid;
  logic [QCNT_W-1:0] q_count;
  frame_t            wr_frame, rd_frame;

  ecef_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_raw   (in_tdata[RAW_BITS-1:0]),
    .in_level (in_tdata[RAW_BITS]),
    .q_full   (q_full),
    .push     (push),
    .frame    (wr_frame)
  );

  ecef_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_frame (wr_frame),
    .pop      (pop),
    .rd_frame (rd_frame),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_count  (q_count)
  );

  ecef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .rd_frame  (rd_frame),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  // an index request never produces a frame record
  a_index_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_tvalid && in_tready && in_tuser == CMD_TICK))
    else $error("frame record pushed for a non-tick request");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("frame queue overfilled");

  // output goes idle after the last byte only when nothing is queued
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !q_valid) |=> !out_tvalid)
    else $error("output still valid with no frame queued");

  a_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && q_valid) |=> out_tvalid)
    else $error("queued frame not started after last byte");

endmodule
